### rtl/core/chacha20_keystream_block_core_macros.svh
// Assertion macros for the ChaCha20 keystream block core.
// Used by chacha20_keystream_block_core.sv; needs nothing else.
`ifndef CHACHA20_KEYSTREAM_BLOCK_CORE_MACROS_SVH
`define CHACHA20_KEYSTREAM_BLOCK_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CC20KS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CC20KS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cc20ks_pkg.sv
// Types, constants and the quarter-round step function of the ChaCha20 keystream core.
// No dependencies.
package cc20ks_pkg;

    localparam int BYTE_COUNT_W = 7;
    localparam int BYTES_VALID_W = 4;
    localparam int CFG_IDX_W = 3;

    typedef logic [31:0] t_word;
    typedef logic [63:0] t_dword;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

    // "expand 32-byte k"
    localparam t_word SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

    // Quarter-round sub-steps, one add each
    localparam logic [1:0] STEP_AD16 = 2'd0;
    localparam logic [1:0] STEP_CB12 = 2'd1;
    localparam logic [1:0] STEP_AD8  = 2'd2;
    localparam logic [1:0] STEP_CB7  = 2'd3;

    function automatic t_word rotl32(input t_word v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic t_quad qr_step(input t_quad q, input logic [1:0] step);
        t_quad r;
        t_word x;
        r = q;
        x = '0;
        case (step)
            STEP_AD16: begin
                x   = q.a + q.b;
                r.a = x;
                r.d = rotl32(q.d ^ x, 16);
            end
            STEP_CB12: begin
                x   = q.c + q.d;
                r.c = x;
                r.b = rotl32(q.b ^ x, 12);
            end
            STEP_AD8: begin
                x   = q.a + q.b;
                r.a = x;
                r.d = rotl32(q.d ^ x, 8);
            end
            STEP_CB7: begin
                x   = q.c + q.d;
                r.c = x;
                r.b = rotl32(q.b ^ x, 7);
            end
            default: begin
                r = q;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/core/cc20ks_req_if.sv
// Request channel of the ChaCha20 keystream core: restart flag and byte count.
// Depends on cc20ks_pkg.
interface cc20ks_req_if import cc20ks_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    restart;
    logic [BYTE_COUNT_W-1:0] byte_count;

    modport source (output valid, output restart, output byte_count, input ready);
    modport sink   (input valid, input restart, input byte_count, output ready);
endinterface

### rtl/core/cc20ks_word_if.sv
// Keystream word channel of the ChaCha20 keystream core.
// Depends on cc20ks_pkg.
interface cc20ks_word_if import cc20ks_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [63:0]              keystream_word;
    logic [BYTES_VALID_W-1:0] bytes_valid;
    logic                     last_word;

    modport source (output valid, output keystream_word, output bytes_valid,
                    output last_word, input ready);
    modport sink   (input valid, input keystream_word, input bytes_valid,
                    input last_word, output ready);
endinterface

### rtl/core/cc20ks_cfg_if.sv
// Configuration write channel of the ChaCha20 keystream core: index and data.
// Depends on cc20ks_pkg.
interface cc20ks_cfg_if import cc20ks_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/chacha20_keystream_block_core.sv
// ChaCha20 keystream generator, 64-bit nonce / 64-bit block counter variant.
// Depends on cc20ks_pkg, the three channel interfaces and the macros header.
//
// Channels: i_cfg writes key parts 0..3 (index 0..3) and the nonce (index 4);
// it is always ready and must only be used while the core is idle. i_req asks
// for one 64-byte block: restart clears the block counter first, byte_count
// (1..64, larger saturates) picks how many 64-bit words go out on o_word. A
// request with byte_count zero produces nothing and leaves the counter alone,
// though restart still applies.
// Operation: the request cycle loads the state, then four quarter-round lanes
// run one add/xor/rotate sub-step per cycle through ROUND_COUNT rounds (odd
// counts rounded up), then ST_FINAL adds the input state back and advances the
// counter. Words then leave at one per cycle while o_word.ready is high.
// One block is in flight at a time; i_req.ready is low from acceptance until
// the last word is taken. A stalled receiver simply holds the current word.
// Reset clears the key, nonce and block counter and returns to idle.
`include "chacha20_keystream_block_core_macros.svh"

module chacha20_keystream_block_core
    import cc20ks_pkg::*;
#(
    parameter int ROUND_COUNT = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cc20ks_cfg_if.sink    i_cfg,
    cc20ks_req_if.sink    i_req,
    cc20ks_word_if.source o_word
);

    localparam int DOUBLES = (ROUND_COUNT + 1) / 2;
    localparam int HALVES  = 2 * DOUBLES;
    localparam int HALF_W  = (HALVES > 1) ? $clog2(HALVES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FINAL = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_dword              r_key [4];
    t_dword              r_nonce;
    t_dword              r_ctr;
    t_word               r_work [16];
    t_word               n_work [16];
    logic [1:0]          r_step;
    logic [HALF_W-1:0]   r_half;
    logic [2:0]          r_word;
    logic [2:0]          r_last_idx;
    logic [3:0]          r_last_bytes;

    t_word               w_init [16];
    t_dword              w_ctr_sel;
    logic                w_req_acc;
    logic                w_out_acc;
    logic                w_is_last;
    logic [BYTE_COUNT_W-1:0] w_cnt;
    logic [BYTE_COUNT_W-1:0] w_cnt_m1;
    logic [3:0]          w_ia [4];
    logic [3:0]          w_ib [4];
    logic [3:0]          w_ic [4];
    logic [3:0]          w_id [4];
    t_quad               w_lane_in [4];
    t_quad               w_lane_out [4];

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_out_acc   = o_word.valid && o_word.ready;
    assign w_is_last   = (r_word == r_last_idx);

    // Counter as seen by the state load: a restart in the same request wins
    assign w_ctr_sel = (r_state == ST_IDLE && i_req.restart) ? '0 : r_ctr;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_init[i]         = SIGMA[i];
            w_init[4 + 2 * i] = r_key[i][31:0];
            w_init[5 + 2 * i] = r_key[i][63:32];
        end
        w_init[12] = w_ctr_sel[31:0];
        w_init[13] = w_ctr_sel[63:32];
        w_init[14] = r_nonce[31:0];
        w_init[15] = r_nonce[63:32];
    end

    assign w_cnt    = (i_req.byte_count > 7'd64) ? 7'd64 : i_req.byte_count;
    assign w_cnt_m1 = w_cnt - 7'd1;

    // Lane j works on column j, or on diagonal j on odd half-rounds
    for (genvar j = 0; j < 4; j++) begin : g_lane
        assign w_ia[j] = {2'b00, 2'(j)};
        assign w_ib[j] = {2'b01, 2'(j) + {1'b0, r_half[0]}};
        assign w_ic[j] = {2'b10, 2'(j) + {r_half[0], 1'b0}};
        assign w_id[j] = {2'b11, 2'(j) + {r_half[0], r_half[0]}};
        assign w_lane_in[j] = '{a: r_work[w_ia[j]], b: r_work[w_ib[j]],
                                c: r_work[w_ic[j]], d: r_work[w_id[j]]};
        assign w_lane_out[j] = qr_step(w_lane_in[j], r_step);
    end

    always_comb begin
        n_work = r_work;
        case (r_state)
            ST_IDLE: begin
                n_work = w_init;
            end
            ST_ROUND: begin
                for (int j = 0; j < 4; j++) begin
                    n_work[w_ia[j]] = w_lane_out[j].a;
                    n_work[w_ib[j]] = w_lane_out[j].b;
                    n_work[w_ic[j]] = w_lane_out[j].c;
                    n_work[w_id[j]] = w_lane_out[j].d;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 16; i++) begin
                    n_work[i] = r_work[i] + w_init[i];
                end
            end
            ST_OUT: begin
                n_work = r_work;
            end
            default: begin
                n_work = r_work;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_req_acc && i_req.byte_count != '0) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_step == STEP_CB7 && r_half == HALF_W'(HALVES - 1)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_acc && w_is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ctr   <= '0;
            r_nonce <= '0;
            r_step  <= '0;
            r_half  <= '0;
            r_word  <= '0;
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_KEY0:  r_key[0] <= i_cfg.data;
                    CFG_KEY1:  r_key[1] <= i_cfg.data;
                    CFG_KEY2:  r_key[2] <= i_cfg.data;
                    CFG_KEY3:  r_key[3] <= i_cfg.data;
                    CFG_NONCE: r_nonce  <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (w_req_acc) begin
                r_ctr  <= w_ctr_sel;
                r_step <= '0;
                r_half <= '0;
                r_word <= '0;
            end
            if (r_state == ST_ROUND) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_CB7) begin
                    r_half <= r_half + HALF_W'(1);
                end
            end
            // advance the counter in the same cycle as the input state is added back
            if (r_state == ST_FINAL) begin
                r_ctr <= r_ctr + 64'd1;
            end
            if (w_out_acc && !w_is_last) begin
                r_word <= r_word + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        if (w_req_acc) begin
            r_last_idx   <= w_cnt_m1[5:3];
            r_last_bytes <= {1'b0, w_cnt_m1[2:0]} + 4'd1;
        end
    end

    assign o_word.valid          = (r_state == ST_OUT);
    assign o_word.keystream_word = {r_work[{r_word, 1'b1}], r_work[{r_word, 1'b0}]};
    assign o_word.bytes_valid    = w_is_last ? r_last_bytes : 4'd8;
    assign o_word.last_word      = w_is_last;

    `CC20KS_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, 1'b1, !(i_req.ready && o_word.valid), "request taken while a block is still going out")
    `CC20KS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, w_req_acc && i_req.byte_count != '0, !i_req.ready, "core did not start on a nonzero request")
    `CC20KS_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, w_out_acc && o_word.last_word, i_req.ready, "core not idle after the last word")
    `CC20KS_ASSERT_NEXT(a_ctr_step, i_clk, i_rst_n, r_state == ST_FINAL, r_ctr == $past(r_ctr) + 64'd1, "block counter did not advance by one")

endmodule
